/* hw/rtl/cbs_pkg.sv */
// Shared types and constants for the cubic Bezier split pipeline.
// No dependencies; cbs_pipe_ctrl and cubic_bezier_split_unit import this package.
`timescale 1ns / 1ps

package cbs_pkg;

  // Two register stages per de Casteljau level, three levels.
  localparam int NUM_STAGES = 6;

  // Stage indexes: the multiply and add stage of each level.
  localparam int ST_L1_MUL = 0;
  localparam int ST_L1_ADD = 1;
  localparam int ST_L2_MUL = 2;
  localparam int ST_L2_ADD = 3;
  localparam int ST_L3_MUL = 4;
  localparam int ST_L3_ADD = 5;

  // Guard bits on the coordinate width: with t below 2.0 each level can grow
  // the magnitude by up to three times, so three levels need five bits, plus
  // one for the floor of the shift.
  localparam int GUARD_BITS = 6;

  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
    logic [NUM_STAGES-1:0] vld;
  } pipe_ctrl_t;

endpackage

/* hw/rtl/cbs_in_if.sv */
// Input channel of the cubic Bezier split block: valid/ready and one curve.
// Standalone interface; widths follow the block parameters.
`timescale 1ns / 1ps

interface cbs_in_if #(
  parameter int COORD_WIDTH = 24,
  parameter int T_FRAC_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] p0_x;
  logic signed [COORD_WIDTH-1:0] p0_y;
  logic signed [COORD_WIDTH-1:0] p1_x;
  logic signed [COORD_WIDTH-1:0] p1_y;
  logic signed [COORD_WIDTH-1:0] p2_x;
  logic signed [COORD_WIDTH-1:0] p2_y;
  logic signed [COORD_WIDTH-1:0] p3_x;
  logic signed [COORD_WIDTH-1:0] p3_y;
  logic        [T_FRAC_BITS:0]   split_t;

  modport source (
    output valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, split_t,
    input  ready
  );
  modport sink (
    input  valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, split_t,
    output ready
  );
endinterface

/* hw/rtl/cbs_out_if.sv */
// Result channel of the cubic Bezier split block: valid/ready and the five
// inner points of the two halves. Standalone interface.
`timescale 1ns / 1ps

interface cbs_out_if #(
  parameter int COORD_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] left_ctrl1_x;
  logic signed [COORD_WIDTH-1:0] left_ctrl1_y;
  logic signed [COORD_WIDTH-1:0] left_ctrl2_x;
  logic signed [COORD_WIDTH-1:0] left_ctrl2_y;
  logic signed [COORD_WIDTH-1:0] split_point_x;
  logic signed [COORD_WIDTH-1:0] split_point_y;
  logic signed [COORD_WIDTH-1:0] right_ctrl1_x;
  logic signed [COORD_WIDTH-1:0] right_ctrl1_y;
  logic signed [COORD_WIDTH-1:0] right_ctrl2_x;
  logic signed [COORD_WIDTH-1:0] right_ctrl2_y;

  modport source (
    output valid, left_ctrl1_x, left_ctrl1_y, left_ctrl2_x, left_ctrl2_y,
           split_point_x, split_point_y, right_ctrl1_x, right_ctrl1_y,
           right_ctrl2_x, right_ctrl2_y,
    input  ready
  );
  modport sink (
    input  valid, left_ctrl1_x, left_ctrl1_y, left_ctrl2_x, left_ctrl2_y,
           split_point_x, split_point_y, right_ctrl1_x, right_ctrl1_y,
           right_ctrl2_x, right_ctrl2_y,
    output ready
  );
endinterface

/* hw/rtl/cbs_pipe_ctrl.sv */
// Valid and stage-enable chain of the split pipeline.
// Depends on cbs_pkg for the stage count and the control struct.
`timescale 1ns / 1ps

module cbs_pipe_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               out_ready,
  output logic               in_ready,
  output cbs_pkg::pipe_ctrl_t ctrl
);
  import cbs_pkg::*;

  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] vld_nxt;
  logic [NUM_STAGES-1:0] en;

  // A stage loads when it is empty or its contents move on, so bubbles
  // collapse and a stall holds each occupied stage that has no empty stage ahead.
  always_comb begin
    en[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || out_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  always_comb begin
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    for (int i = 1; i < NUM_STAGES; i++) begin
      vld_nxt[i] = en[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready = en[0];
  assign ctrl.en  = en;
  assign ctrl.vld = vld_r;

endmodule

/* hw/rtl/cbs_lerp.sv */
// Two-stage linear interpolation a + floor((b - a) * t / 2^T_FRAC_BITS).
// Stage one subtracts and multiplies, stage two shifts and adds.
`timescale 1ns / 1ps

module cbs_lerp #(
  parameter int VAL_WIDTH   = 30,
  parameter int T_FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        en_mul,
  input  logic                        en_add,
  input  logic signed [VAL_WIDTH-1:0] a,
  input  logic signed [VAL_WIDTH-1:0] b,
  input  logic        [T_FRAC_BITS:0] t,
  output logic signed [VAL_WIDTH-1:0] y
);
  localparam int DIFF_WIDTH = VAL_WIDTH + 1;
  localparam int PROD_WIDTH = DIFF_WIDTH + T_FRAC_BITS + 2;

  logic signed [DIFF_WIDTH-1:0] diff;
  logic signed [T_FRAC_BITS+1:0] t_s;
  logic signed [PROD_WIDTH-1:0] prod_nxt;
  logic signed [PROD_WIDTH-1:0] prod_r;
  logic signed [VAL_WIDTH-1:0]  a_r;
  logic signed [VAL_WIDTH-1:0]  y_r;

  assign diff     = DIFF_WIDTH'(b) - DIFF_WIDTH'(a);
  assign t_s      = $signed({1'b0, t});
  assign prod_nxt = PROD_WIDTH'(diff) * PROD_WIDTH'(t_s);

  always_ff @(posedge clk) begin
    if (en_mul) begin
      a_r    <= a;
      prod_r <= prod_nxt;
    end
  end

  // Taking the bits above the fraction is the arithmetic shift, i.e. floor.
  always_ff @(posedge clk) begin
    if (en_add) begin
      y_r <= a_r + $signed(prod_r[T_FRAC_BITS +: VAL_WIDTH]);
    end
  end

  assign y = y_r;

endmodule

/* hw/rtl/cubic_bezier_split_unit.sv */
// Cubic Bezier subdivision at parameter t (de Casteljau, three levels).
// Depends on cbs_pkg, cbs_in_if, cbs_out_if, cbs_pipe_ctrl and cbs_lerp.
//
// Usage:
//   in_ch carries one curve per transaction: four control points in signed
//   fixed point and split_t in unsigned Q1.T_FRAC_BITS. out_ch returns one
//   transaction per curve with the inner control points of the left half,
//   the split point and the inner control points of the right half, in the
//   order the curves arrived.
//   An accepted curve is loaded into the six register stages in order,
//   starting at the accepting edge; each of the three interpolation levels
//   takes one multiply stage and one add stage.
//   Throughput is one curve per cycle while out_ch does not stall; the
//   6-stage pipeline holds up to six curves in flight.
//   When out_ch stalls, occupied stages hold their contents and empty
//   stages keep filling, so in_ch.ready drops only once every stage ahead
//   of the stalled result is full.
//   Reset (rst_n low, synchronous) empties the pipeline; no result is valid
//   afterwards until a new curve has passed through.
//   Intermediate points carry six guard bits so split_t above one
//   extrapolates exactly; results are wrapped to COORD_WIDTH bits.
`timescale 1ns / 1ps

module cubic_bezier_split_unit #(
  parameter int COORD_WIDTH = 24,
  parameter int T_FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  cbs_in_if.sink     in_ch,
  cbs_out_if.source  out_ch
);
  import cbs_pkg::*;

  localparam int IW = COORD_WIDTH + GUARD_BITS;
  localparam int TW = T_FRAC_BITS + 1;

  pipe_ctrl_t ctrl;

  cbs_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .in_ready  (in_ch.ready),
    .ctrl      (ctrl)
  );

  assign out_ch.valid = ctrl.vld[ST_L3_ADD];

  // split_t travels alongside the data to the entry of each later level.
  logic [TW-1:0] t1_r, t2_r, t3_r, t4_r;

  always_ff @(posedge clk) begin
    if (ctrl.en[ST_L1_MUL]) t1_r <= in_ch.split_t;
    if (ctrl.en[ST_L1_ADD]) t2_r <= t1_r;
    if (ctrl.en[ST_L2_MUL]) t3_r <= t2_r;
    if (ctrl.en[ST_L2_ADD]) t4_r <= t3_r;
  end

  for (genvar k = 0; k < 2; k++) begin : g_axis
    logic signed [COORD_WIDTH-1:0] p0, p1, p2, p3;
    logic signed [IW-1:0] p0_e, p1_e, p2_e, p3_e;
    logic signed [IW-1:0] lc1, m12, rc2, lc2, rc1, sp;
    logic signed [IW-1:0] lc1_d3_r, lc1_d4_r, lc1_d5_r, lc1_d6_r;
    logic signed [IW-1:0] rc2_d3_r, rc2_d4_r, rc2_d5_r, rc2_d6_r;
    logic signed [IW-1:0] lc2_d5_r, lc2_d6_r, rc1_d5_r, rc1_d6_r;

    assign p0 = (k == 0) ? in_ch.p0_x : in_ch.p0_y;
    assign p1 = (k == 0) ? in_ch.p1_x : in_ch.p1_y;
    assign p2 = (k == 0) ? in_ch.p2_x : in_ch.p2_y;
    assign p3 = (k == 0) ? in_ch.p3_x : in_ch.p3_y;

    assign p0_e = {{GUARD_BITS{p0[COORD_WIDTH-1]}}, p0};
    assign p1_e = {{GUARD_BITS{p1[COORD_WIDTH-1]}}, p1};
    assign p2_e = {{GUARD_BITS{p2[COORD_WIDTH-1]}}, p2};
    assign p3_e = {{GUARD_BITS{p3[COORD_WIDTH-1]}}, p3};

    cbs_lerp #(.VAL_WIDTH(IW), .T_FRAC_BITS(T_FRAC_BITS)) u_lc1 (
      .clk(clk), .en_mul(ctrl.en[ST_L1_MUL]), .en_add(ctrl.en[ST_L1_ADD]),
      .a(p0_e), .b(p1_e), .t(in_ch.split_t), .y(lc1)
    );
    cbs_lerp #(.VAL_WIDTH(IW), .T_FRAC_BITS(T_FRAC_BITS)) u_m12 (
      .clk(clk), .en_mul(ctrl.en[ST_L1_MUL]), .en_add(ctrl.en[ST_L1_ADD]),
      .a(p1_e), .b(p2_e), .t(in_ch.split_t), .y(m12)
    );
    cbs_lerp #(.VAL_WIDTH(IW), .T_FRAC_BITS(T_FRAC_BITS)) u_rc2 (
      .clk(clk), .en_mul(ctrl.en[ST_L1_MUL]), .en_add(ctrl.en[ST_L1_ADD]),
      .a(p2_e), .b(p3_e), .t(in_ch.split_t), .y(rc2)
    );

    cbs_lerp #(.VAL_WIDTH(IW), .T_FRAC_BITS(T_FRAC_BITS)) u_lc2 (
      .clk(clk), .en_mul(ctrl.en[ST_L2_MUL]), .en_add(ctrl.en[ST_L2_ADD]),
      .a(lc1), .b(m12), .t(t2_r), .y(lc2)
    );
    cbs_lerp #(.VAL_WIDTH(IW), .T_FRAC_BITS(T_FRAC_BITS)) u_rc1 (
      .clk(clk), .en_mul(ctrl.en[ST_L2_MUL]), .en_add(ctrl.en[ST_L2_ADD]),
      .a(m12), .b(rc2), .t(t2_r), .y(rc1)
    );

    cbs_lerp #(.VAL_WIDTH(IW), .T_FRAC_BITS(T_FRAC_BITS)) u_sp (
      .clk(clk), .en_mul(ctrl.en[ST_L3_MUL]), .en_add(ctrl.en[ST_L3_ADD]),
      .a(lc2), .b(rc1), .t(t4_r), .y(sp)
    );

    // Level results that are already final ride along to the output stage.
    always_ff @(posedge clk) begin
      if (ctrl.en[ST_L2_MUL]) begin
        lc1_d3_r <= lc1;
        rc2_d3_r <= rc2;
      end
      if (ctrl.en[ST_L2_ADD]) begin
        lc1_d4_r <= lc1_d3_r;
        rc2_d4_r <= rc2_d3_r;
      end
      if (ctrl.en[ST_L3_MUL]) begin
        lc1_d5_r <= lc1_d4_r;
        rc2_d5_r <= rc2_d4_r;
        lc2_d5_r <= lc2;
        rc1_d5_r <= rc1;
      end
      if (ctrl.en[ST_L3_ADD]) begin
        lc1_d6_r <= lc1_d5_r;
        rc2_d6_r <= rc2_d5_r;
        lc2_d6_r <= lc2_d5_r;
        rc1_d6_r <= rc1_d5_r;
      end
    end

    if (k == 0) begin : g_x
      assign out_ch.left_ctrl1_x  = lc1_d6_r[COORD_WIDTH-1:0];
      assign out_ch.left_ctrl2_x  = lc2_d6_r[COORD_WIDTH-1:0];
      assign out_ch.split_point_x = sp[COORD_WIDTH-1:0];
      assign out_ch.right_ctrl1_x = rc1_d6_r[COORD_WIDTH-1:0];
      assign out_ch.right_ctrl2_x = rc2_d6_r[COORD_WIDTH-1:0];
    end else begin : g_y
      assign out_ch.left_ctrl1_y  = lc1_d6_r[COORD_WIDTH-1:0];
      assign out_ch.left_ctrl2_y  = lc2_d6_r[COORD_WIDTH-1:0];
      assign out_ch.split_point_y = sp[COORD_WIDTH-1:0];
      assign out_ch.right_ctrl1_y = rc1_d6_r[COORD_WIDTH-1:0];
      assign out_ch.right_ctrl2_y = rc2_d6_r[COORD_WIDTH-1:0];
    end
  end

endmodule
